// ===== design/protobuf_wire_tokenizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the protobuf wire tokenizer
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_WIRE_TOKENIZER_TOP_ASSERT_SVH
`define PROTOBUF_WIRE_TOKENIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwt: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define PWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwt: next-cycle property failed");

`endif

// ===== design/pwt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwt_pkg
// Types and codes shared by the protobuf wire tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

  // Event codes of a result word.
  localparam logic [2:0] EV_TAG     = 3'd0;
  localparam logic [2:0] EV_VARINT  = 3'd1;
  localparam logic [2:0] EV_LENGTH  = 3'd2;
  localparam logic [2:0] EV_PAYLOAD = 3'd3;
  localparam logic [2:0] EV_FIXED   = 3'd4;
  localparam logic [2:0] EV_ERROR   = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_TRUNCATED = 2'd0;
  localparam logic [1:0] ERR_WIRE_TYPE = 2'd1;
  localparam logic [1:0] ERR_MALFORMED = 2'd2;

  // Accepted wire types.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Index of the tenth varint byte, the last one allowed.
  localparam logic [3:0] VARINT_LAST = 4'd9;

  localparam logic [63:0] FIXED64_BYTES = 64'd8;
  localparam logic [63:0] FIXED32_BYTES = 64'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] field_num;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        field_done;
    logic        buffer_end;
  } result_t;

endpackage

`default_nettype wire

// ===== design/pwt_intf.sv =====
// ----------------------------------------------------------------------------
// pwt channel interfaces
// Valid/ready channels for buffer bytes in and tokenizer results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] field_num;
  logic [2:0]  wire_type;
  logic [63:0] value;
  logic [7:0]  payload_byte;
  logic [1:0]  error_code;
  logic        field_done;
  logic        buffer_end;

  modport source (output valid, output event_res, output field_num, output wire_type,
                  output value, output payload_byte, output error_code, output field_done,
                  output buffer_end, input ready);
  modport sink   (input valid, input event_res, input field_num, input wire_type,
                  input value, input payload_byte, input error_code, input field_done,
                  input buffer_end, output ready);
endinterface

`default_nettype wire

// ===== design/protobuf_wire_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer_top
// Byte-serial tokenizer for protobuf wire-format buffers.
//
//   Channel  Dir  Word contents
//   in_ch    in   data_byte, last_byte (end of buffer)
//   out_ch   out  event_res, field_num, wire_type, value, payload_byte,
//                 error_code, field_done, buffer_end
//
// One byte is accepted per clock while out_ch does not stall; the decoder
// step, which lies between the input and output registers, sets that rate.
// Bytes that produce no result (inner varint and fixed bytes, drained bytes)
// leave nothing on out_ch. A stall on out_ch holds the input register and
// then in_ch. Reset (rst_n low, synchronous) empties both registers and
// returns the decoder to expecting a key.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_wire_tokenizer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  pwt_in_if.sink    in_ch,
  pwt_out_if.source out_ch
);

  logic              s1_valid;
  pwt_pkg::in_word_t s1_word;
  logic              out_free;
  logic              step;
  logic              has_res;
  pwt_pkg::result_t  res;

  assign step = s1_valid && out_free;

  pwt_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (step),
    .in_ch (in_ch),
    .valid (s1_valid),
    .word  (s1_word)
  );

  pwt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .word    (s1_word),
    .has_res (has_res),
    .res     (res)
  );

  pwt_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .has_res (has_res),
    .res     (res),
    .free    (out_free),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/pwt_in_stage.sv =====
// ----------------------------------------------------------------------------
// pwt_in_stage
// Input register: holds one buffer byte until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  pwt_in_if.sink                in_ch,
  output logic                  valid,
  output pwt_pkg::in_word_t     word
);

  logic              valid_r;
  pwt_pkg::in_word_t word_r;

  assign in_ch.ready = !valid_r || take;
  assign valid       = valid_r;
  assign word        = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r.data_byte <= in_ch.data_byte;
      word_r.last_byte <= in_ch.last_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/pwt_core.sv =====
// ----------------------------------------------------------------------------
// pwt_core
// Tokenizer state machine: decodes one byte per step into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "protobuf_wire_tokenizer_top_assert.svh"

module pwt_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire pwt_pkg::in_word_t word,
  output logic                   has_res,
  output pwt_pkg::result_t       res
);

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VALUE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_FIXED,
    PH_DRAIN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] held_fn_r, held_fn_nxt;
  logic [2:0]  held_wt_r, held_wt_nxt;

  // Varint byte folding.
  logic [3:0]  n_eff;
  logic [5:0]  sh;
  logic [63:0] acc_f;
  logic        malformed;
  logic        more;
  logic [3:0]  cnt_f;

  logic        is_err;
  logic [2:0]  key_wt;
  logic        wt_ok;

  logic        fixed_rem_ok;
  logic        no_acc_phase;
  logic        held_wt_ok;

  always_comb begin
    n_eff     = (cnt_r > pwt_pkg::VARINT_LAST) ? pwt_pkg::VARINT_LAST : cnt_r;
    sh        = 6'({n_eff, 3'b000} - {3'b000, n_eff});
    acc_f     = acc_r | ({57'd0, word.data_byte[6:0]} << sh);
    malformed = word.data_byte[7] && (n_eff == pwt_pkg::VARINT_LAST);
    more      = word.data_byte[7] && !malformed;
    cnt_f     = more ? (n_eff + 4'd1) : n_eff;
    key_wt    = acc_f[2:0];
    wt_ok     = (key_wt == pwt_pkg::WT_VARINT) || (key_wt == pwt_pkg::WT_FIXED64) ||
                (key_wt == pwt_pkg::WT_LEN) || (key_wt == pwt_pkg::WT_FIXED32);
  end

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    held_fn_nxt = held_fn_r;
    held_wt_nxt = held_wt_r;
    is_err      = 1'b0;

    has_res          = 1'b0;
    res.event_res    = pwt_pkg::EV_TAG;
    res.field_num    = held_fn_r;
    res.wire_type    = held_wt_r;
    res.value        = '0;
    res.payload_byte = '0;
    res.error_code   = pwt_pkg::ERR_TRUNCATED;
    res.field_done   = 1'b0;
    res.buffer_end   = word.last_byte;

    case (phase_r)
      PH_TAG: begin
        acc_nxt          = acc_f;
        cnt_nxt          = cnt_f;
        res.field_num    = acc_f[34:3];
        res.wire_type    = key_wt;
        if (malformed) begin
          is_err         = 1'b1;
          res.error_code = pwt_pkg::ERR_MALFORMED;
        end else if (more) begin
          is_err = word.last_byte;
        end else if (!wt_ok) begin
          is_err         = 1'b1;
          res.error_code = pwt_pkg::ERR_WIRE_TYPE;
        end else if (word.last_byte) begin
          is_err = 1'b1;
        end else begin
          has_res     = 1'b1;
          held_fn_nxt = acc_f[34:3];
          held_wt_nxt = key_wt;
          acc_nxt     = '0;
          cnt_nxt     = '0;
          if (key_wt == pwt_pkg::WT_VARINT) begin
            phase_nxt = PH_VALUE;
          end else if (key_wt == pwt_pkg::WT_LEN) begin
            phase_nxt = PH_LENGTH;
          end else begin
            phase_nxt = PH_FIXED;
            rem_nxt   = (key_wt == pwt_pkg::WT_FIXED64) ? pwt_pkg::FIXED64_BYTES
                                                        : pwt_pkg::FIXED32_BYTES;
          end
        end
      end
      PH_VALUE, PH_LENGTH: begin
        acc_nxt = acc_f;
        cnt_nxt = cnt_f;
        if (malformed) begin
          is_err         = 1'b1;
          res.error_code = pwt_pkg::ERR_MALFORMED;
        end else if (more) begin
          is_err = word.last_byte;
        end else if (phase_r == PH_VALUE) begin
          has_res        = 1'b1;
          res.event_res  = pwt_pkg::EV_VARINT;
          res.value      = acc_f;
          res.field_done = 1'b1;
          phase_nxt      = PH_TAG;
          acc_nxt        = '0;
          cnt_nxt        = '0;
        end else if (acc_f == '0) begin
          // A zero length closes the field on the length itself.
          has_res        = 1'b1;
          res.event_res  = pwt_pkg::EV_LENGTH;
          res.field_done = 1'b1;
          phase_nxt      = PH_TAG;
          acc_nxt        = '0;
          cnt_nxt        = '0;
        end else if (word.last_byte) begin
          is_err = 1'b1;
        end else begin
          has_res       = 1'b1;
          res.event_res = pwt_pkg::EV_LENGTH;
          res.value     = acc_f;
          rem_nxt       = acc_f;
          phase_nxt     = PH_PAYLOAD;
          acc_nxt       = '0;
          cnt_nxt       = '0;
        end
      end
      PH_PAYLOAD: begin
        res.payload_byte = word.data_byte;
        if (rem_r <= 64'd1) begin
          has_res        = 1'b1;
          res.event_res  = pwt_pkg::EV_PAYLOAD;
          res.field_done = 1'b1;
          rem_nxt        = '0;
          phase_nxt      = PH_TAG;
        end else if (word.last_byte) begin
          is_err = 1'b1;
        end else begin
          has_res       = 1'b1;
          res.event_res = pwt_pkg::EV_PAYLOAD;
          rem_nxt       = rem_r - 64'd1;
        end
      end
      PH_FIXED: begin
        if (rem_r <= 64'd1) begin
          has_res        = 1'b1;
          res.event_res  = pwt_pkg::EV_FIXED;
          res.field_done = 1'b1;
          rem_nxt        = '0;
          phase_nxt      = PH_TAG;
        end else if (word.last_byte) begin
          is_err = 1'b1;
        end else begin
          rem_nxt = rem_r - 64'd1;
        end
      end
      default: begin
      end
    endcase

    // An error drains the rest of the buffer; a buffer end restarts field decoding.
    if (is_err) begin
      has_res       = 1'b1;
      res.event_res = pwt_pkg::EV_ERROR;
      res.value     = '0;
      phase_nxt     = word.last_byte ? PH_TAG : PH_DRAIN;
      acc_nxt       = '0;
      cnt_nxt       = '0;
    end else if (word.last_byte) begin
      phase_nxt = PH_TAG;
      acc_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      acc_r     <= '0;
      cnt_r     <= '0;
      rem_r     <= '0;
      held_fn_r <= '0;
      held_wt_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      rem_r     <= rem_nxt;
      held_fn_r <= held_fn_nxt;
      held_wt_r <= held_wt_nxt;
    end
  end

  assign fixed_rem_ok = (rem_r != 64'd0) && (rem_r <= pwt_pkg::FIXED64_BYTES);
  assign no_acc_phase = (phase_r == PH_PAYLOAD) || (phase_r == PH_FIXED) ||
                        (phase_r == PH_DRAIN);
  assign held_wt_ok   = (held_wt_r == pwt_pkg::WT_VARINT) || (held_wt_r == pwt_pkg::WT_FIXED64) ||
                        (held_wt_r == pwt_pkg::WT_LEN) || (held_wt_r == pwt_pkg::WT_FIXED32);

  `PWT_ASSERT_IMPL(a_payload_left, phase_r == PH_PAYLOAD, rem_r != 64'd0)
  `PWT_ASSERT_IMPL(a_fixed_left, phase_r == PH_FIXED, fixed_rem_ok)
  `PWT_ASSERT_IMPL(a_acc_idle, no_acc_phase, (acc_r == 64'd0) && (cnt_r == 4'd0))
  `PWT_ASSERT_NEXT(a_last_to_tag, step && word.last_byte, phase_r == PH_TAG)
  `PWT_ASSERT_IMPL(a_held_wt_ok, 1'b1, held_wt_ok)

endmodule

`default_nettype wire

// ===== design/pwt_out_stage.sv =====
// ----------------------------------------------------------------------------
// pwt_out_stage
// Output register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             has_res,
  input  wire pwt_pkg::result_t res,
  output logic                  free,
  pwt_out_if.source             out_ch
);

  logic             valid_r;
  pwt_pkg::result_t res_r;

  // The register can load when empty or when its word leaves this cycle.
  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= step && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (free && step && has_res) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.field_num    = res_r.field_num;
  assign out_ch.wire_type    = res_r.wire_type;
  assign out_ch.value        = res_r.value;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.error_code   = res_r.error_code;
  assign out_ch.field_done   = res_r.field_done;
  assign out_ch.buffer_end   = res_r.buffer_end;

endmodule

`default_nettype wire

// ===== bench/tb_protobuf_wire_tokenizer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for protobuf_wire_tokenizer_top
// Feeds encoded buffers byte by byte, predicts every result word from a
// behavioral tokenizer kept in the bench, and compares each received word
// field by field. Directed buffers cover each event and error; random
// buffers are mostly well-formed, with truncated, malformed and noise ones
// mixed in, under several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

module tb_protobuf_wire_tokenizer_top;

  localparam int unsigned TIMEOUT_NS = 5_000_000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  // Wire types the tokenizer rejects.
  localparam logic [2:0] WT_START_GROUP = 3'd3;
  localparam logic [2:0] WT_END_GROUP   = 3'd4;
  localparam logic [2:0] WT_RESERVED6   = 3'd6;
  localparam logic [2:0] WT_RESERVED7   = 3'd7;

  typedef enum logic [2:0] {
    ST_KEY, ST_VARINT, ST_LEN, ST_PAYLOAD, ST_FIXED, ST_DRAIN
  } decode_state_t;

  typedef enum logic [1:0] {VARINT_MORE, VARINT_DONE, VARINT_OVERLONG} varint_status_t;

  logic clk;
  logic rst_n;

  pwt_in_if  in_if ();
  pwt_out_if out_if ();

  protobuf_wire_tokenizer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Tokenizer state mirrored by the bench.
  decode_state_t decode_state;
  logic [63:0]   varint_acc;
  logic [3:0]    varint_len;
  logic [63:0]   bytes_left;
  logic [31:0]   cur_field;
  logic [2:0]    cur_wire_type;

  pwt_pkg::result_t pending_results[$];
  logic [7:0]       frame_bytes[$];
  int               mismatches;
  int               bytes_sent;
  int               sender_idle_pct;
  int               receiver_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic void enter_state(input decode_state_t s);
    decode_state = s;
    varint_acc = '0;
    varint_len = '0;
  endfunction

  function automatic varint_status_t absorb_varint_byte(input logic [7:0] b);
    logic [3:0] n;
    n = (varint_len > pwt_pkg::VARINT_LAST) ? pwt_pkg::VARINT_LAST : varint_len;
    varint_acc |= 64'(b[6:0]) << (7 * n);
    if (!b[7]) return VARINT_DONE;
    if (n >= pwt_pkg::VARINT_LAST) return VARINT_OVERLONG;
    varint_len = n + 4'd1;
    return VARINT_MORE;
  endfunction

  // Advances the mirrored tokenizer by one byte and queues the word it yields.
  task automatic tokenize_byte(input logic [7:0] b, input logic last);
    pwt_pkg::result_t w;
    logic             emit;
    varint_status_t   st;
    w = '0;
    emit = 1'b0;
    w.field_num = cur_field;
    w.wire_type = cur_wire_type;
    w.buffer_end = last;
    case (decode_state)
      ST_KEY: begin
        st = absorb_varint_byte(b);
        w.field_num = varint_acc[34:3];
        w.wire_type = varint_acc[2:0];
        if (st == VARINT_OVERLONG) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
          w.error_code = pwt_pkg::ERR_MALFORMED;
        end else if (st == VARINT_MORE) begin
          if (last) begin
            emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
          end
        end else if (w.wire_type == WT_START_GROUP || w.wire_type == WT_END_GROUP ||
                     w.wire_type > pwt_pkg::WT_FIXED32) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
          w.error_code = pwt_pkg::ERR_WIRE_TYPE;
        end else if (last) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
        end else begin
          emit = 1'b1;
          w.event_res = pwt_pkg::EV_TAG;
          cur_field = w.field_num;
          cur_wire_type = w.wire_type;
          if (w.wire_type == pwt_pkg::WT_VARINT) begin
            enter_state(ST_VARINT);
          end else if (w.wire_type == pwt_pkg::WT_LEN) begin
            enter_state(ST_LEN);
          end else begin
            enter_state(ST_FIXED);
            bytes_left = (w.wire_type == pwt_pkg::WT_FIXED64) ? pwt_pkg::FIXED64_BYTES
                                                              : pwt_pkg::FIXED32_BYTES;
          end
        end
      end
      ST_VARINT, ST_LEN: begin
        st = absorb_varint_byte(b);
        if (st == VARINT_OVERLONG) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
          w.error_code = pwt_pkg::ERR_MALFORMED;
        end else if (st == VARINT_MORE) begin
          if (last) begin
            emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
          end
        end else if (decode_state == ST_VARINT) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_VARINT;
          w.value = varint_acc; w.field_done = 1'b1;
          enter_state(ST_KEY);
        end else if (varint_acc == '0) begin
          // A zero length closes the field on the length word itself.
          emit = 1'b1; w.event_res = pwt_pkg::EV_LENGTH; w.field_done = 1'b1;
          enter_state(ST_KEY);
        end else if (last) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
        end else begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_LENGTH; w.value = varint_acc;
          bytes_left = varint_acc;
          enter_state(ST_PAYLOAD);
        end
      end
      ST_PAYLOAD: begin
        emit = 1'b1;
        w.payload_byte = b;
        if (bytes_left < 64'd2) begin
          w.event_res = pwt_pkg::EV_PAYLOAD; w.field_done = 1'b1;
          bytes_left = '0;
          enter_state(ST_KEY);
        end else if (last) begin
          w.event_res = pwt_pkg::EV_ERROR;
        end else begin
          w.event_res = pwt_pkg::EV_PAYLOAD;
          bytes_left = bytes_left - 64'd1;
        end
      end
      ST_FIXED: begin
        if (bytes_left < 64'd2) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_FIXED; w.field_done = 1'b1;
          bytes_left = '0;
          enter_state(ST_KEY);
        end else if (last) begin
          emit = 1'b1; w.event_res = pwt_pkg::EV_ERROR;
        end else begin
          bytes_left = bytes_left - 64'd1;
        end
      end
      default: begin
      end
    endcase
    if (emit && w.event_res == pwt_pkg::EV_ERROR) begin
      enter_state(last ? ST_KEY : ST_DRAIN);
    end else if (last) begin
      enter_state(ST_KEY);
    end
    if (emit) pending_results.insert(pending_results.size(), w);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output words are checked before the byte accepted on the same edge is
  // predicted; a byte cannot produce its word on the edge it is taken.
  always @(posedge clk) begin
    pwt_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, got event %0d",
                 $time, out_if.event_res);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", want.event_res, out_if.event_res);
        check_field("field_num", want.field_num, out_if.field_num);
        check_field("wire_type", want.wire_type, out_if.wire_type);
        check_field("value", want.value, out_if.value);
        check_field("payload_byte", want.payload_byte, out_if.payload_byte);
        check_field("error_code", want.error_code, out_if.error_code);
        check_field("field_done", want.field_done, out_if.field_done);
        check_field("buffer_end", want.buffer_end, out_if.buffer_end);
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      tokenize_byte(in_if.data_byte, in_if.last_byte);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Holds the sender off until every predicted word has come out or DRAIN_LIMIT runs out.
  task automatic wait_for_results();
    int guard;
    in_if.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  // Encodes a varint, padded with redundant continuation groups up to min_len (at most ten).
  function automatic void push_varint(input logic [63:0] v, input int min_len);
    int          groups;
    logic [63:0] rest;
    groups = 1;
    rest = v >> 7;
    while (rest != '0) begin
      groups++;
      rest = rest >> 7;
    end
    if (min_len > groups) groups = (min_len > 10) ? 10 : min_len;
    for (int i = 0; i < groups; i++) begin
      add_byte({i < groups - 1, 7'(v >> (7 * i))});
    end
  endfunction

  // Ten or more bytes that all carry a continuation bit.
  function automatic void push_overlong();
    repeat ($urandom_range(12, 10)) add_byte({1'b1, 7'($urandom)});
  endfunction

  function automatic int pick_varint_pad();
    return ($urandom_range(9) == 0) ? $urandom_range(10, 2) : 0;
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(300));
      3:       return {$urandom, $urandom};
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  function automatic logic [31:0] pick_field_num();
    case ($urandom_range(9))
      0:             return 32'hFFFF_FFFF;
      1:             return '0;
      2, 3, 4, 5:    return 32'($urandom_range(15, 1));
      default:       return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [2:0] pick_wire_type();
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(3))
        0:       return WT_START_GROUP;
        1:       return WT_END_GROUP;
        2:       return WT_RESERVED6;
        default: return WT_RESERVED7;
      endcase
    end
    case ($urandom_range(3))
      0:       return pwt_pkg::WT_VARINT;
      1:       return pwt_pkg::WT_FIXED64;
      2:       return pwt_pkg::WT_LEN;
      default: return pwt_pkg::WT_FIXED32;
    endcase
  endfunction

  function automatic void build_random_frame();
    int          nfields;
    int          keep;
    logic [2:0]  wt;
    logic [63:0] key;
    logic [63:0] len;
    logic        cut;
    frame_bytes.delete();
    cut = ($urandom_range(99) < 15);
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
    end else begin
      nfields = $urandom_range(4, 1);
      for (int f = 0; f < nfields; f++) begin
        wt = pick_wire_type();
        key = {29'b0, pick_field_num(), wt};
        // Keys wider than 35 bits only keep their low field number bits.
        if ($urandom_range(19) == 0) key[63:35] = 29'({$urandom, $urandom});
        if ($urandom_range(49) == 0) begin
          push_overlong();
          break;
        end
        push_varint(key, pick_varint_pad());
        if (wt == pwt_pkg::WT_VARINT) begin
          if ($urandom_range(29) == 0) begin
            push_overlong();
            break;
          end
          push_varint(pick_value(), pick_varint_pad());
        end else if (wt == pwt_pkg::WT_LEN) begin
          if ($urandom_range(29) == 0) begin
            // A huge length that the buffer can never satisfy.
            push_varint({$urandom, $urandom} | 64'h100, 0);
            repeat ($urandom_range(5)) add_byte(8'($urandom));
            break;
          end
          len = ($urandom_range(9) == 0) ? 64'($urandom_range(40)) : 64'($urandom_range(6));
          push_varint(len, pick_varint_pad());
          repeat (len) add_byte(8'($urandom));
        end else if (wt == pwt_pkg::WT_FIXED64) begin
          repeat (8) add_byte(8'($urandom));
        end else if (wt == pwt_pkg::WT_FIXED32) begin
          repeat (4) add_byte(8'($urandom));
        end else begin
          // Rejected key: whatever follows is dropped until the buffer ends.
          repeat ($urandom_range(3)) add_byte(8'($urandom));
          break;
        end
      end
    end
    if (cut && frame_bytes.size() > 1) begin
      keep = $urandom_range(frame_bytes.size() - 1, 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
  endfunction

  task automatic test_field_kinds();
    // Varint zero, zero length, one payload byte, then a fixed32 ending the buffer.
    frame_bytes = '{8'h08, 8'h00, 8'h12, 8'h00, 8'h1A, 8'h01, 8'hFF,
                    8'h0D, 8'h11, 8'h22, 8'h33, 8'h44};
    send_frame();
    wait_for_results();
  endtask

  task automatic test_wire_type_errors();
    frame_bytes = '{8'h0B, 8'h00};
    send_frame();
    frame_bytes = '{8'h0F};
    send_frame();
    wait_for_results();
  endtask

  task automatic test_truncation();
    frame_bytes = '{8'h80};
    send_frame();
    frame_bytes = '{8'h08};
    send_frame();
    frame_bytes = '{8'h12, 8'h03};
    send_frame();
    frame_bytes = '{8'h0A, 8'h02, 8'h5A};
    send_frame();
    frame_bytes = '{8'h0D, 8'h01};
    send_frame();
    wait_for_results();
  endtask

  task automatic test_malformed_varint();
    // The tenth byte still continues and is also the last byte of the buffer.
    frame_bytes.delete();
    repeat (10) add_byte(8'hFF);
    send_frame();
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int budget);
    int start;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_random_frame();
      send_frame();
    end
    wait_for_results();
  endtask

  initial begin
    mismatches = 0;
    bytes_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    enter_state(ST_KEY);
    bytes_left = '0;
    cur_field = '0;
    cur_wire_type = '0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_kinds();
    test_wire_type_errors();
    test_truncation();
    test_malformed_varint();
    test_random_traffic(0, 0, 300);
    test_random_traffic(45, 0, 300);
    test_random_traffic(0, 45, 300);
    test_random_traffic(19, 19, 300);

    if (pending_results.size() != 0) begin
      $display("%0t ns: expected %0d more result words, got none", $time,
               pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
